// ===== hw/rtl/pre_pkg.sv =====
// Shared types and constants for the page replacement engine.
package pre_pkg;
   localparam int Pages = 256;
   localparam int Frames = 8;
   localparam int PageW = $clog2(Pages);
   localparam int FrameW = (Frames > 1) ? $clog2(Frames) : 1;
   localparam int CountW = $clog2(Frames + 1);

   typedef enum logic [0:0] {
      POLICY_FIFO = 1'b0,
      POLICY_LRU  = 1'b1
   } policy_type;

   typedef enum logic [0:0] {
      CSR_POLICY_MODE   = 1'b0,
      CSR_FRAMES_IN_USE = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_DECIDE,
      ST_UPDATE,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic lookup;   // register page and issue table read
      logic decide;   // hit/miss check, victim selection
      logic update;   // write back tables, emit response
      logic flush;    // clear one page valid bit
   } cmd_type;

   typedef struct packed {
      logic flush_done;
   } status_type;
endpackage

// ===== hw/rtl/pre_datapath.sv =====
// Datapath: page table, resident list, counters and response registers.
module pre_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  pre_pkg::cmd_type      cmd,
   output pre_pkg::status_type   status,
   input  logic                  csr_write,
   input  logic                  csr_index,
   input  logic [3:0]            csr_data,
   input  logic [pre_pkg::PageW-1:0] req_page_number,
   output logic                  rsp_valid,
   output logic                  rsp_fault,
   output logic                  rsp_evict_valid,
   output logic [7:0]            rsp_evicted_page,
   output logic [2:0]            rsp_frame_index,
   output logic [31:0]           rsp_fault_total
);
   import pre_pkg::*;

   logic [Pages-1:0]      valid_ff;
   logic [FrameW-1:0]     frame_mem [Pages];
   logic [PageW-1:0]      list_ff [Frames];
   logic [CountW-1:0]     occ_ff, cap_ff;
   logic [FrameW-1:0]     oldest_ff;
   logic                  policy_ff;
   logic [31:0]           tally_ff;
   logic [PageW-1:0]      page_ff, victim_ff;
   logic                  hitr_ff, evict_ff;
   logic [FrameW-1:0]     pframe_ff, vframe_ff, slot_ff;
   logic [PageW-1:0]      flush_ff;
   logic                  flush_done_ff;

   logic [CountW-1:0]     cap_in;
   logic [FrameW-1:0]     pos;
   logic [FrameW-1:0]     oldest_next;
   logic [FrameW-1:0]     frame_pick;
   logic [FrameW-1:0]     last_slot;

   always_comb begin
      cap_in = CountW'(csr_data);
      if (csr_data == 4'd0) cap_in = CountW'(1);
      else if (csr_data > 4'(Frames)) cap_in = CountW'(Frames);
   end

   // locate the hit page in the resident list
   always_comb begin
      pos = '0;
      for (int i = Frames - 1; i >= 0; i--)
         if (CountW'(i) < occ_ff && list_ff[i] == page_ff) pos = FrameW'(i);
   end

   always_comb begin
      if ({1'b0, oldest_ff} + 1'b1 >= (FrameW+1)'(cap_ff)) oldest_next = '0;
      else oldest_next = oldest_ff + 1'b1;
   end

   assign last_slot = FrameW'(occ_ff - 1'b1);

   // page table frame store
   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         pframe_ff <= frame_mem[req_page_number];
      end
      if (cmd.decide) begin
         vframe_ff <= frame_mem[policy_ff ? list_ff[0] : list_ff[oldest_ff]];
      end
      if (cmd.update && !hitr_ff) begin
         frame_mem[page_ff] <= frame_pick;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.lookup) page_ff <= req_page_number;
      if (cmd.decide) begin
         hitr_ff  <= valid_ff[page_ff];
         evict_ff <= !valid_ff[page_ff] && occ_ff >= cap_ff;
         slot_ff  <= valid_ff[page_ff] ? pos : (policy_ff ? '0 : oldest_ff);
         victim_ff <= policy_ff ? list_ff[0] : list_ff[oldest_ff];
      end
   end

   always_comb begin
      frame_pick = pframe_ff;
      if (!hitr_ff) frame_pick = evict_ff ? vframe_ff : FrameW'(occ_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         occ_ff <= '0;
         oldest_ff <= '0;
         cap_ff <= CountW'(Frames);
         policy_ff <= POLICY_FIFO;
         tally_ff <= '0;
         flush_ff <= '0;
         flush_done_ff <= 1'b1;
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= 1'b0;
         // clear one page valid bit per cycle
         if (cmd.flush) begin
            valid_ff[flush_ff] <= 1'b0;
            flush_ff <= flush_ff + 1'b1;
            if (flush_ff == '1) flush_done_ff <= 1'b1;
         end
         if (csr_write && csr_index == CSR_POLICY_MODE) policy_ff <= csr_data[0];
         if (csr_write && csr_index == CSR_FRAMES_IN_USE) begin
            cap_ff <= cap_in;
            occ_ff <= '0;
            oldest_ff <= '0;
            flush_ff <= '0;
            flush_done_ff <= 1'b0;
         end
         if (cmd.update) begin
            if (hitr_ff) begin
               if (policy_ff == POLICY_LRU) begin
                  for (int i = 0; i < Frames - 1; i++)
                     if (FrameW'(i) >= slot_ff && CountW'(i + 1) < occ_ff)
                        list_ff[i] <= list_ff[i + 1];
                  list_ff[last_slot] <= page_ff;
               end
            end else begin
               if (tally_ff != '1) tally_ff <= tally_ff + 1'b1;
               valid_ff[page_ff] <= 1'b1;
               if (!evict_ff) begin
                  list_ff[occ_ff[FrameW-1:0]] <= page_ff;
                  occ_ff <= occ_ff + 1'b1;
               end else begin
                  valid_ff[victim_ff] <= 1'b0;
                  if (policy_ff == POLICY_LRU) begin
                     for (int i = 0; i < Frames - 1; i++)
                        if (CountW'(i + 1) < occ_ff) list_ff[i] <= list_ff[i + 1];
                     list_ff[last_slot] <= page_ff;
                  end else begin
                     list_ff[oldest_ff] <= page_ff;
                     oldest_ff <= oldest_next;
                  end
               end
            end
            rsp_valid <= 1'b1;
         end
      end
   end

   assign status.flush_done = flush_done_ff;

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         rsp_fault <= !hitr_ff;
         rsp_evict_valid <= !hitr_ff && evict_ff;
         rsp_evicted_page <= (!hitr_ff && evict_ff) ? 8'(victim_ff) : 8'd0;
         rsp_frame_index <= 3'(frame_pick);
         rsp_fault_total <= (!hitr_ff && tally_ff != '1) ? tally_ff + 1'b1 : tally_ff;
      end
   end
endmodule

// ===== hw/rtl/pre_controller.sv =====
// Controller: sequences lookup, decide and update for one transaction.
module pre_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_start,
   output logic                 req_busy,
   output pre_pkg::cmd_type     cmd,
   input  pre_pkg::status_type  status
);
   import pre_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_busy = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_busy = !status.flush_done;
            if (!status.flush_done) begin
               state_in = ST_FLUSH;
            end else if (req_start) begin
               cmd.lookup = 1'b1;
               state_in = ST_DECIDE;
            end
         end
         ST_LOOKUP: state_in = ST_DECIDE;
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in = ST_IDLE;
         end
         ST_FLUSH: begin
            // hold until every page valid bit is cleared
            if (status.flush_done) state_in = ST_IDLE;
            else cmd.flush = 1'b1;
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule

// ===== hw/rtl/page_replacement_engine_core.sv =====
// Page replacement engine (FIFO / LRU) top level.
// One access per transaction: a transaction is taken when req_start is high and
// req_busy low, and its result appears as a one-cycle rsp_valid strobe after the
// lookup, decide and update steps; req_busy stays high for the decide and update
// steps, so the block takes no new access before the last one is done, as the two
// single-port page-table reads (accessed page, then victim) come ahead of the list update. The
// receiver cannot stall; results must be taken on the strobe. Write the csr_
// registers only while idle; a frames_in_use write empties all frames and
// clears the page valid bits one per cycle, holding req_busy high while it does so.
module page_replacement_engine_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_start,
   output logic        req_busy,
   input  logic [7:0]  req_page_number,
   output logic        rsp_valid,
   output logic        rsp_hit,
   output logic        rsp_fault,
   output logic        rsp_evict_valid,
   output logic [7:0]  rsp_evicted_page,
   output logic [2:0]  rsp_frame_index,
   output logic [31:0] rsp_fault_total,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [3:0]  csr_data
);
   import pre_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       strobe;

   pre_controller u_ctrl (
      .clock, .reset, .req_start, .req_busy, .cmd, .status
   );

   pre_datapath u_dp (
      .clock, .reset, .cmd, .status, .csr_write, .csr_index, .csr_data,
      .req_page_number(req_page_number[PageW-1:0]),
      .rsp_valid(strobe), .rsp_fault, .rsp_evict_valid, .rsp_evicted_page,
      .rsp_frame_index, .rsp_fault_total
   );

   // rsp_hit: hit flag is the inverse of fault while strobed
   assign rsp_valid = strobe;
   assign rsp_hit = !rsp_fault;
endmodule

// ===== hw/rtl/pre_checker.sv =====
// Port-level checker for the page replacement engine, bound to the top level.
module pre_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_start,
   input logic        req_busy,
   input logic        rsp_valid,
   input logic        rsp_fault,
   input logic        rsp_evict_valid,
   input logic [31:0] rsp_fault_total
);
   a_resp_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_start && !req_busy |-> ##3 rsp_valid) else $error("missing response");
   a_busy_during: assert property (@(posedge clock) disable iff (reset)
      req_start && !req_busy |=> req_busy) else $error("busy not raised");
   a_evict_fault: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_evict_valid |-> rsp_fault) else $error("evict without fault");
   a_no_back2back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("double strobe");
   a_fault_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fault |-> rsp_fault_total != 32'd0) else $error("fault not counted");
endmodule

bind page_replacement_engine_core pre_checker u_chk (
   .clock, .reset, .req_start, .req_busy, .rsp_valid, .rsp_fault,
   .rsp_evict_valid, .rsp_fault_total
);

// ===== verif/tb_top.sv =====
// Testbench for page_replacement_engine_core: directed and random page accesses checked against a predictor.
`timescale 1ns / 100ps
module tb_top;
   import pre_pkg::*;

   typedef struct packed {
      logic        hit;
      logic        fault;
      logic        evict_valid;
      logic [7:0]  evicted_page;
      logic [2:0]  frame_index;
      logic [31:0] fault_total;
   } access_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_start = 1'b0;
   logic        req_busy;
   logic [7:0]  req_page_number = '0;
   logic        rsp_valid;
   logic        rsp_hit;
   logic        rsp_fault;
   logic        rsp_evict_valid;
   logic [7:0]  rsp_evicted_page;
   logic [2:0]  rsp_frame_index;
   logic [31:0] rsp_fault_total;
   logic        csr_write = 1'b0;
   logic        csr_index = 1'b0;
   logic [3:0]  csr_data = '0;

   page_replacement_engine_core u_dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // shadow copy of the page table and resident list
   logic        shadow_valid [Pages];
   logic [2:0]  shadow_frame [Pages];
   logic [7:0]  shadow_list [Frames];
   int unsigned shadow_occ, shadow_oldest, shadow_cap;
   logic [31:0] shadow_faults;
   policy_type  shadow_policy;

   access_result_type pending_results [$];
   int errors = 0;
   int idle_cycles = 0;

   function automatic void flush_shadow();
      for (int p = 0; p < Pages; p++) begin
         shadow_valid[p] = 1'b0;
         shadow_frame[p] = '0;
      end
      for (int s = 0; s < Frames; s++) shadow_list[s] = '0;
      shadow_occ = 0;
      shadow_oldest = 0;
   endfunction

   // shift slots pos+1 .. occ-1 down, then put page at the most-recent end
   function automatic void promote_page(int unsigned pos, logic [7:0] page);
      for (int unsigned i = pos; i + 1 < shadow_occ; i++) shadow_list[i] = shadow_list[i + 1];
      shadow_list[shadow_occ - 1] = page;
   endfunction

   function automatic access_result_type predict_access(logic [7:0] page);
      access_result_type r;
      logic [7:0] victim;
      int unsigned slot;
      r = '0;
      if (shadow_valid[page]) begin
         r.hit = 1'b1;
         r.frame_index = shadow_frame[page];
         if (shadow_policy == POLICY_LRU) begin
            for (int unsigned i = 0; i < shadow_occ; i++) begin
               if (shadow_list[i] == page) begin
                  promote_page(i, page);
                  break;
               end
            end
         end
      end else begin
         r.fault = 1'b1;
         if (shadow_faults != 32'hFFFF_FFFF) shadow_faults++;
         if (shadow_occ < shadow_cap) begin
            slot = shadow_occ;
            shadow_list[slot] = page;
            shadow_frame[page] = slot[2:0];
            shadow_occ++;
            r.frame_index = slot[2:0];
         end else begin
            if (shadow_policy == POLICY_LRU) begin
               victim = shadow_list[0];
               promote_page(0, page);
            end else begin
               slot = shadow_oldest % shadow_cap;
               victim = shadow_list[slot];
               shadow_list[slot] = page;
               shadow_oldest = (slot + 1) % shadow_cap;
            end
            shadow_valid[victim] = 1'b0;
            shadow_frame[page] = shadow_frame[victim];
            r.evict_valid = 1'b1;
            r.evicted_page = victim;
            r.frame_index = shadow_frame[page];
         end
         shadow_valid[page] = 1'b1;
      end
      r.fault_total = shadow_faults;
      return r;
   endfunction

   // send one access after a random gap; start stays high across back-to-back accesses
   task automatic send_access(logic [7:0] page);
      int gap;
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
      if ($urandom_range(0, 7) == 0) gap = 0;
      if (gap > 0 && req_start) begin
         req_start <= 1'b0;
         repeat (gap) @(posedge clock);
      end else if (gap > 0) begin
         repeat (gap) @(posedge clock);
      end
      req_start <= 1'b1;
      req_page_number <= page;
      do @(posedge clock); while (req_busy);
      pending_results.push_back(predict_access(page));
   endtask

   task automatic wait_drained();
      if (req_start) begin
         req_start <= 1'b0;
         @(posedge clock);
      end
      while (pending_results.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [3:0] value);
      wait_drained();
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == CSR_POLICY_MODE) begin
         shadow_policy = policy_type'(value[0]);
      end else begin
         shadow_cap = value == 0 ? 1 : (value > Frames ? Frames : value);
         flush_shadow();
      end
      repeat (2) @(posedge clock);
   endtask

   always @(posedge clock) begin
      access_result_type want, got;
      if (!reset && rsp_valid) begin
         got = '{rsp_hit, rsp_fault, rsp_evict_valid, rsp_evicted_page, rsp_frame_index,
                 rsp_fault_total};
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result, actual %h", $time, got);
            errors++;
         end else begin
            want = pending_results.pop_front();
            if (got.hit != want.hit || got.fault != want.fault ||
                got.evict_valid != want.evict_valid || got.frame_index != want.frame_index ||
                got.fault_total != want.fault_total ||
                (want.evict_valid && got.evicted_page != want.evicted_page)) begin
               $display("%0t: mismatch, expected %h actual %h", $time, want, got);
               errors++;
            end
         end
      end
   end

   // watchdog: cycles without any transaction
   always @(posedge clock) begin
      if ((req_start && !req_busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic test_fifo_directed();
      write_csr(CSR_POLICY_MODE, 4'(POLICY_FIFO));
      for (int p = 0; p < 8; p++) send_access(p == 7 ? 8'hFF : p[7:0]);
      send_access(8'h00);
      send_access(8'hFF);
      send_access(8'h80);
      send_access(8'h81);
      send_access(8'h00);
   endtask

   task automatic test_lru_directed();
      write_csr(CSR_POLICY_MODE, 4'(POLICY_LRU));
      write_csr(CSR_FRAMES_IN_USE, 4'd3);
      send_access(8'h10);
      send_access(8'h20);
      send_access(8'h30);
      send_access(8'h10);
      send_access(8'h40);
      send_access(8'h30);
      send_access(8'h50);
   endtask

   task automatic test_frame_count_limits();
      write_csr(CSR_FRAMES_IN_USE, 4'd0);
      send_access(8'h01);
      send_access(8'h01);
      send_access(8'h02);
      write_csr(CSR_FRAMES_IN_USE, 4'd15);
      for (int p = 0; p < 9; p++) send_access(8'hAA ^ p[7:0]);
   endtask

   task automatic test_policy_switch();
      write_csr(CSR_FRAMES_IN_USE, 4'd4);
      write_csr(CSR_POLICY_MODE, 4'(POLICY_FIFO));
      for (int p = 0; p < 5; p++) send_access(p[7:0]);
      write_csr(CSR_POLICY_MODE, 4'(POLICY_LRU));
      send_access(8'h09);
      write_csr(CSR_POLICY_MODE, 4'(POLICY_FIFO));
      send_access(8'h0A);
   endtask

   task automatic test_random_traffic();
      int unsigned base, span;
      logic [7:0] page;
      for (int phase = 0; phase < 17; phase++) begin
         write_csr(CSR_POLICY_MODE, 4'($urandom_range(0, 1)));
         if (phase % 3 == 0) write_csr(CSR_FRAMES_IN_USE, 4'($urandom_range(0, 15)));
         if (phase == 8) wait_drained();
         base = $urandom_range(0, 255);
         span = $urandom_range(1, 12);
         for (int k = 0; k < 100; k++) begin
            if ($urandom_range(0, 4) == 0) page = 8'($urandom_range(0, 255));
            else page = 8'((base + $urandom_range(0, span)) % 256);
            send_access(page);
         end
      end
   endtask

   initial begin
      shadow_policy = POLICY_FIFO;
      shadow_cap = Frames;
      shadow_faults = '0;
      flush_shadow();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_fifo_directed();
      test_lru_directed();
      test_frame_count_limits();
      test_policy_switch();
      test_random_traffic();
      wait_drained();
      repeat (10) @(posedge clock);
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule

// ===== page_replacement_engine_core.f =====
hw/rtl/pre_pkg.sv
hw/rtl/pre_datapath.sv
hw/rtl/pre_controller.sv
hw/rtl/page_replacement_engine_core.sv
hw/rtl/pre_checker.sv
verif/tb_top.sv
